FILE: sv/msr_pkg.sv
// Shared types and constants for the motor soft-start ramp unit.
`default_nettype none

package msr_pkg;

	localparam int unsigned SpeedW   = 8;
	localparam int unsigned HoldW    = 16;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutDataW = 16;

	typedef logic [SpeedW-1:0] speed_t;
	typedef logic [HoldW-1:0]  hold_t;

	typedef enum logic {
		KIND_TICK    = 1'b0,
		KIND_COMMAND = 1'b1
	} item_kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RAMP_STEP       = 2'd0,
		CFG_SLOW_ZONE_LIMIT = 2'd1,
		CFG_SLOW_HOLD_TICKS = 2'd2,
		CFG_FAST_HOLD_TICKS = 2'd3
	} cfg_idx_t;

	localparam speed_t RAMP_STEP_RST       = 8'd2;
	localparam speed_t SLOW_ZONE_LIMIT_RST = 8'd10;
	localparam hold_t  SLOW_HOLD_TICKS_RST = 16'd3000;
	localparam hold_t  FAST_HOLD_TICKS_RST = 16'd500;
	localparam speed_t SPEED_MAX           = 8'hFF;

	typedef struct packed {
		item_kind_t kind;
		logic       run;
		speed_t     target_speed;
		logic       turn_direction;
	} in_item_t;

	typedef struct packed {
		logic   speed_write;
		speed_t speed_value;
		logic   dir_write;
		logic   dir_value;
		logic   driver_enable;
		logic   ramping;
	} out_item_t;

endpackage

`default_nettype wire

FILE: sv/motor_soft_start_ramp_unit.sv
// Soft-start speed ramp for one motor driver: tick and command items in, driver updates out.
// Takes one item per clock cycle when the output side keeps up; each accepted item passes through the
// input register and then the result register before its result is presented. The ramp state
// (speed, goal, hold counter, enable, ramp flag) is updated by one combinational step of compare,
// saturating add and counter reload per item, so consecutive items never wait on each other.
// Configuration writes take effect on the next cycle and are meant to be made while idle.
`default_nettype none

module motor_soft_start_ramp_unit
	import msr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_idx,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	// input stream
	input  wire logic                s_tvalid,
	output      logic                s_tready,
	input  wire logic [InDataW-1:0]  s_tdata,  // run, target_speed[7:0], turn_direction, pad
	input  wire logic                s_tuser,  // kind
	// result stream
	output      logic                m_tvalid,
	input  wire logic                m_tready,
	output      logic [OutDataW-1:0] m_tdata   // speed_write, speed_value[7:0], dir_write,
	                                           // dir_value, driver_enable, ramping, pad
);

	// configuration registers
	speed_t ramp_step_q;
	speed_t slow_zone_q;
	hold_t  slow_hold_q;
	hold_t  fast_hold_q;

	// ramp state
	speed_t present_q;
	speed_t goal_q;
	logic   ramp_q;
	hold_t  hold_q;
	logic   enabled_q;

	// pipeline
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t out_s2;

	logic adv_s1;
	logic load_s1;

	// next-state logic
	speed_t     pres_n;
	speed_t     goal_n;
	logic       ramp_n;
	hold_t      hold_n;
	logic       en_n;
	out_item_t  res;
	logic [SpeedW:0] sum;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= RAMP_STEP_RST;
			slow_zone_q <= SLOW_ZONE_LIMIT_RST;
			slow_hold_q <= SLOW_HOLD_TICKS_RST;
			fast_hold_q <= FAST_HOLD_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_RAMP_STEP:       ramp_step_q <= cfg_wdata[SpeedW-1:0];
				CFG_SLOW_ZONE_LIMIT: slow_zone_q <= cfg_wdata[SpeedW-1:0];
				CFG_SLOW_HOLD_TICKS: slow_hold_q <= cfg_wdata[HoldW-1:0];
				CFG_FAST_HOLD_TICKS: fast_hold_q <= cfg_wdata[HoldW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.kind           <= item_kind_t'(s_tuser);
			item_s1.run            <= s_tdata[0];
			item_s1.target_speed   <= s_tdata[SpeedW:1];
			item_s1.turn_direction <= s_tdata[SpeedW+1];
		end
	end

	always_comb begin
		pres_n = present_q;
		goal_n = goal_q;
		ramp_n = ramp_q;
		hold_n = hold_q;
		en_n   = enabled_q;
		res    = '0;
		sum    = '0;

		if (item_s1.kind == KIND_TICK) begin
			if (hold_q != '0) begin
				hold_n = hold_q - hold_t'(1);
			end
		end else if (item_s1.run) begin
			res.dir_write = 1'b1;
			res.dir_value = item_s1.turn_direction;
			goal_n        = item_s1.target_speed;
			if (item_s1.target_speed > present_q) begin
				ramp_n = 1'b1;
			end else begin
				pres_n          = item_s1.target_speed;
				res.speed_write = 1'b1;
				res.speed_value = item_s1.target_speed;
			end
			en_n = 1'b1;
		end else begin
			pres_n          = '0;
			res.speed_write = 1'b1;
			res.speed_value = '0;
			en_n            = 1'b0;
			ramp_n          = 1'b0;
		end

		if (ramp_n && hold_n == '0) begin
			if (pres_n < goal_n) begin
				sum    = {1'b0, pres_n} + {1'b0, ramp_step_q};
				pres_n = sum[SpeedW] ? SPEED_MAX : sum[SpeedW-1:0];
				hold_n = (pres_n <= slow_zone_q) ? slow_hold_q : fast_hold_q;
			end else begin
				pres_n = goal_n;
				ramp_n = 1'b0;
			end
			res.speed_write = 1'b1;
			res.speed_value = pres_n;
		end

		res.driver_enable = en_n;
		res.ramping       = ramp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			goal_q    <= '0;
			ramp_q    <= 1'b0;
			hold_q    <= '0;
			enabled_q <= 1'b0;
		end else if (adv_s1) begin
			present_q <= pres_n;
			goal_q    <= goal_n;
			ramp_q    <= ramp_n;
			hold_q    <= hold_n;
			enabled_q <= en_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, out_s2.ramping, out_s2.driver_enable, out_s2.dir_value,
		out_s2.dir_write, out_s2.speed_value, out_s2.speed_write};

	// a stop command clears the speed, the enable and the ramp
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.kind == KIND_COMMAND && !item_s1.run
		|=> present_q == '0 && !enabled_q && !ramp_q)
		else $error("stop command left the ramp state set");

	// a run command enables the driver
	a_run_enables: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.kind == KIND_COMMAND && item_s1.run |=> enabled_q)
		else $error("run command did not enable the driver");

	// ramp state moves only when an item advances
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(present_q) && $stable(hold_q) && $stable(ramp_q))
		else $error("ramp state changed without an item");

	// the reported flags follow the state that was stored with the result
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_s2.ramping == ramp_q && out_s2.driver_enable == enabled_q)
		else $error("result flags disagree with ramp state");

endmodule

`default_nettype wire
